@@ rtl/core/ansi_utf8_terminal_byte_parser_defines.svh @@
// Assertion macros for the terminal byte parser.
// No dependencies; included by the top level.
`ifndef ANSI_UTF8_TERMINAL_BYTE_PARSER_DEFINES_SVH
`define ANSI_UTF8_TERMINAL_BYTE_PARSER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ATP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ATP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/atp_pkg.sv @@
// Shared types and constants of the terminal byte parser.
// No dependencies.
package atp_pkg;

  localparam int unsigned ParamBufferLen = 32;
  localparam int unsigned PcW = $clog2(ParamBufferLen);

  localparam logic [31:0] DefaultFg = 32'he6ebf4ff;
  localparam logic [31:0] DefaultBg = 32'h000000ff;
  localparam logic [20:0] Replacement = 21'h00fffd;
  localparam logic [7:0] EscByte = 8'h1b;
  localparam logic [7:0] BelByte = 8'h07;

  typedef enum logic [1:0] {
    ActAppend = 2'd0,
    ActNewLine = 2'd1,
    ActBackspace = 2'd2,
    ActClear = 2'd3
  } action_e;

  // Front-to-back queue entry
  typedef struct packed {
    action_e     action;
    logic [20:0] codepoint;
  } cmd_t;

  function automatic logic [31:0] palette(input logic [2:0] idx);
    logic [31:0] c;
    case (idx)
      3'd0: c = 32'h000000ff;
      3'd1: c = 32'hcd3131ff;
      3'd2: c = 32'h0dbc79ff;
      3'd3: c = 32'he5e510ff;
      3'd4: c = 32'h2472c8ff;
      3'd5: c = 32'hbc3fbcff;
      3'd6: c = 32'h11a8cdff;
      default: c = 32'he5e5e5ff;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/atp_front.sv @@
// Front part: escape tracking, CSI/SGR parsing, UTF-8 decode, colors.
// Depends on atp_pkg.
module atp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [7:0]         byte_i,
  output logic               emit_o,
  output atp_pkg::cmd_t      cmd_o,
  output logic [31:0]        fg_o,
  output logic [31:0]        bg_o,
  output logic [2:0]         attr_o
);
  import atp_pkg::*;

  typedef enum logic [4:0] {
    MdNone = 5'b00001, MdStarted = 5'b00010, MdCsi = 5'b00100,
    MdOsc = 5'b01000, MdOscEnd = 5'b10000
  } mode_e;
  typedef enum logic [1:0] {
    PhLeading = 2'd0, PhSign = 2'd1, PhDigits = 2'd2, PhDone = 2'd3
  } phase_e;
  typedef enum logic [1:0] {
    FnIdle = 2'd0, FnRun = 2'd1, FnDone = 2'd2
  } fn_e;

  mode_e mode_q, mode_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [7:0] mag_q, mag_d, fn_q, fn_d;
  phase_e ph_q, ph_d;
  fn_e fph_q, fph_d;
  logic neg_q, neg_d;
  logic [31:0] cfg_q, cfg_d, cbg_q, cbg_d, pfg_q, pfg_d, pbg_q, pbg_d;
  logic [2:0] cat_q, cat_d, pat_q, pat_d;
  logic [20:0] acc_q, acc_d;
  logic [1:0] left_q, left_d;

  logic digit;
  logic [3:0] dv;
  logic [11:0] m10, f10;
  logic [7:0] msat, fsat;
  logic [31:0] afg, abg;
  logic [2:0] aat;
  logic cp_vld;
  logic [20:0] cp;

  // saturating decimal accumulate
  always_comb begin
    digit = byte_i inside {[8'h30:8'h39]};
    dv = byte_i[3:0];
    m10 = {4'd0, mag_q} * 12'd10 + {8'd0, dv};
    f10 = {4'd0, fn_q} * 12'd10 + {8'd0, dv};
    msat = (m10 > 12'd255) ? 8'hff : m10[7:0];
    fsat = (f10 > 12'd255) ? 8'hff : f10[7:0];
  end

  // SGR apply of the current field onto pending
  always_comb begin
    afg = pfg_q;
    abg = pbg_q;
    aat = pat_q;
    if (!(neg_q && mag_q != 8'd0)) begin
      if (mag_q == 8'd0) begin
        afg = DefaultFg; abg = DefaultBg; aat = 3'd0;
      end else if (mag_q == 8'd1) aat = pat_q | 3'd1;
      else if (mag_q == 8'd4) aat = pat_q | 3'd2;
      else if (mag_q == 8'd7) aat = pat_q | 3'd4;
      else if (mag_q inside {[8'd30:8'd37]}) afg = palette(3'(mag_q - 8'd30));
      else if (mag_q inside {[8'd40:8'd47]}) abg = palette(3'(mag_q - 8'd40));
      else if (mag_q == 8'd39) afg = DefaultFg;
      else if (mag_q == 8'd49) abg = DefaultBg;
    end
  end

  always_comb begin
    mode_d = mode_q; pc_d = pc_q; mag_d = mag_q; fn_d = fn_q;
    ph_d = ph_q; fph_d = fph_q; neg_d = neg_q;
    cfg_d = cfg_q; cbg_d = cbg_q; cat_d = cat_q;
    pfg_d = pfg_q; pbg_d = pbg_q; pat_d = pat_q;
    acc_d = acc_q; left_d = left_q;
    emit_o = 1'b0;
    cmd_o = '{action: ActAppend, codepoint: '0};
    cp_vld = 1'b0;
    cp = '0;
    case (mode_q)
      MdStarted: begin
        if (byte_i == 8'h5b) begin
          mode_d = MdCsi; pfg_d = cfg_q; pbg_d = cbg_q; pat_d = cat_q;
        end else if (byte_i == 8'h5d) mode_d = MdOsc;
        else mode_d = MdNone;
      end
      MdOsc: begin
        if (byte_i == BelByte) mode_d = MdNone;
        else if (byte_i == EscByte) mode_d = MdOscEnd;
      end
      MdOscEnd: mode_d = (byte_i == 8'h5c) ? MdNone : MdOsc;
      MdCsi: begin
        if (byte_i inside {[8'h20:8'h3f]}) begin
          if ({1'b0, pc_q} + (PcW+1)'(1) < (PcW+1)'(ParamBufferLen)) begin
            pc_d = pc_q + 1'b1;
            case (fph_q)
              FnIdle: if (digit) begin fn_d = {4'd0, dv}; fph_d = FnRun; end
              FnRun: if (digit) fn_d = fsat; else fph_d = FnDone;
              default: ;
            endcase
            if (byte_i == 8'h3b) begin
              pfg_d = afg; pbg_d = abg; pat_d = aat;
              mag_d = '0; ph_d = PhLeading; neg_d = 1'b0;
            end else begin
              case (ph_q)
                PhLeading: begin
                  if (byte_i == 8'h20) ;
                  else if (byte_i == 8'h2b || byte_i == 8'h2d) begin
                    neg_d = (byte_i == 8'h2d); ph_d = PhSign;
                  end else if (digit) begin
                    mag_d = {4'd0, dv}; ph_d = PhDigits;
                  end else ph_d = PhDone;
                end
                PhSign: begin
                  if (digit) begin mag_d = {4'd0, dv}; ph_d = PhDigits; end
                  else begin mag_d = '0; neg_d = 1'b0; ph_d = PhDone; end
                end
                PhDigits: if (digit) mag_d = msat; else ph_d = PhDone;
                default: ;
              endcase
            end
          end
        end else begin
          if (byte_i == 8'h6d) begin
            pfg_d = afg; pbg_d = abg; pat_d = aat;
            cfg_d = afg; cbg_d = abg; cat_d = aat;
          end else if (byte_i == 8'h4a && fn_q >= 8'd2) begin
            emit_o = 1'b1;
            cmd_o.action = ActClear;
          end
          mode_d = MdNone; pc_d = '0; mag_d = '0; ph_d = PhLeading;
          neg_d = 1'b0; fn_d = '0; fph_d = FnIdle;
        end
      end
      default: begin
        if (byte_i == EscByte) mode_d = MdStarted;
        else if (left_q == 2'd0) begin
          if (!byte_i[7]) begin cp_vld = 1'b1; cp = {13'd0, byte_i}; end
          else if (byte_i[7:5] == 3'b110) begin acc_d = {16'd0, byte_i[4:0]}; left_d = 2'd1; end
          else if (byte_i[7:4] == 4'b1110) begin acc_d = {17'd0, byte_i[3:0]}; left_d = 2'd2; end
          else if (byte_i[7:3] == 5'b11110) begin acc_d = {18'd0, byte_i[2:0]}; left_d = 2'd3; end
          else begin cp_vld = 1'b1; cp = Replacement; end
        end else if (byte_i[7:6] != 2'b10) begin
          left_d = 2'd0; cp_vld = 1'b1; cp = Replacement;
        end else begin
          acc_d = {acc_q[14:0], byte_i[5:0]};
          left_d = left_q - 2'd1;
          if (left_q == 2'd1) begin cp_vld = 1'b1; cp = {acc_q[14:0], byte_i[5:0]}; end
        end
        if (cp_vld) begin
          if (cp == 21'd10) begin emit_o = 1'b1; cmd_o.action = ActNewLine; end
          else if (cp == 21'd8) begin emit_o = 1'b1; cmd_o.action = ActBackspace; end
          else if (cp >= 21'd32 || cp == 21'd9) begin
            emit_o = 1'b1; cmd_o.codepoint = cp;
          end
        end
      end
    endcase
  end

  assign fg_o = cfg_q;
  assign bg_o = cbg_q;
  assign attr_o = cat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MdNone; pc_q <= '0; mag_q <= '0; fn_q <= '0;
      ph_q <= PhLeading; fph_q <= FnIdle; neg_q <= 1'b0;
      cfg_q <= DefaultFg; cbg_q <= DefaultBg; cat_q <= '0;
      pfg_q <= DefaultFg; pbg_q <= DefaultBg; pat_q <= '0;
      acc_q <= '0; left_q <= '0;
    end else if (en_i) begin
      mode_q <= mode_d; pc_q <= pc_d; mag_q <= mag_d; fn_q <= fn_d;
      ph_q <= ph_d; fph_q <= fph_d; neg_q <= neg_d;
      cfg_q <= cfg_d; cbg_q <= cbg_d; cat_q <= cat_d;
      pfg_q <= pfg_d; pbg_q <= pbg_d; pat_q <= pat_d;
      acc_q <= acc_d; left_q <= left_d;
    end
  end
endmodule

@@ rtl/core/atp_queue.sv @@
// Two-entry queue between front and back parts.
// Depends on atp_pkg.
module atp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  atp_pkg::cmd_t      wr_cmd_i,
  input  logic [66:0]        wr_col_i,
  output logic               full_o,
  output logic               rd_valid_o,
  input  logic               rd_i,
  output atp_pkg::cmd_t      rd_cmd_o,
  output logic [66:0]        rd_col_o
);
  import atp_pkg::*;

  cmd_t        cmd_q [2];
  logic [66:0] col_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_cmd_o = cmd_q[rp_q];
  assign rd_col_o = col_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      cmd_q[wp_q] <= wr_cmd_i;
      col_q[wp_q] <= wr_col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end
endmodule

@@ rtl/core/atp_back.sv @@
// Back part: output register that formats and presents actions.
// Depends on atp_pkg.
module atp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  atp_pkg::cmd_t      q_cmd_i,
  input  logic [66:0]        q_col_i,
  output logic               q_rd_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [1:0]         action_o,
  output logic [20:0]        codepoint_o,
  output logic [31:0]        fg_color_o,
  output logic [31:0]        bg_color_o,
  output logic [2:0]         attr_bits_o
);
  import atp_pkg::*;

  logic valid_q;
  logic load;

  assign load = q_valid_i && (!valid_q || ready_i);
  assign q_rd_o = load;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (load) valid_q <= 1'b1;
    else if (ready_i) valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      action_o <= q_cmd_i.action;
      codepoint_o <= q_cmd_i.codepoint;
      if (q_cmd_i.action == ActAppend) begin
        fg_color_o <= q_col_i[66:35];
        bg_color_o <= q_col_i[34:3];
        attr_bits_o <= q_col_i[2:0];
      end else begin
        fg_color_o <= '0; bg_color_o <= '0; attr_bits_o <= '0;
      end
    end
  end
endmodule

@@ rtl/core/ansi_utf8_terminal_byte_parser.sv @@
// Top level of the terminal byte parser: front, queue, back.
// Depends on atp_pkg and ansi_utf8_terminal_byte_parser_defines.svh.
//
//  channel | signals                                   | dir
//  input   | valid_i ready_o data_byte_i               | in
//  output  | valid_o ready_i action_o codepoint_o      | out
//          | fg_color_o bg_color_o attr_bits_o         |
//
// One byte per cycle while the queue is not full: the front decodes a byte in the cycle it is accepted.
// A result enters the two-entry queue at the accepting edge and is loaded into
// the output register, raising valid_o, when it is empty or ready_i is high.
// Input stalls only when the queue is full; a full output register does not
// stall input until the queue fills.
// Reset clears all parser state to defaults and empties the queue.
`include "ansi_utf8_terminal_byte_parser_defines.svh"
module ansi_utf8_terminal_byte_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  action_o,
  output logic [20:0] codepoint_o,
  output logic [31:0] fg_color_o,
  output logic [31:0] bg_color_o,
  output logic [2:0]  attr_bits_o
);
  import atp_pkg::*;

  logic        acc, emit, full, qv, qrd;
  cmd_t        fcmd, qcmd;
  logic [31:0] fg, bg;
  logic [2:0]  at;
  logic [66:0] qcol;

  // Accept whenever the queue can take a possible result.
  assign ready_o = !full;
  assign acc = valid_i && ready_o;

  atp_front u_front (
    .clk_i, .rst_ni, .en_i(acc), .byte_i(data_byte_i),
    .emit_o(emit), .cmd_o(fcmd), .fg_o(fg), .bg_o(bg), .attr_o(at)
  );

  atp_queue u_queue (
    .clk_i, .rst_ni, .wr_i(acc && emit), .wr_cmd_i(fcmd),
    .wr_col_i({fg, bg, at}), .full_o(full), .rd_valid_o(qv),
    .rd_i(qrd), .rd_cmd_o(qcmd), .rd_col_o(qcol)
  );

  atp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_cmd_i(qcmd), .q_col_i(qcol),
    .q_rd_o(qrd), .valid_o, .ready_i, .action_o, .codepoint_o,
    .fg_color_o, .bg_color_o, .attr_bits_o
  );

  `ATP_ASSERT_IMP(a_no_write_full, clk_i, rst_ni, full, !(acc && emit))
  `ATP_ASSERT_IMP(a_nonappend_zero, clk_i, rst_ni,
    valid_o && action_o != ActAppend, codepoint_o == 21'd0 && fg_color_o == 32'd0)
  `ATP_ASSERT_NXT(a_load_valid, clk_i, rst_ni, qrd, valid_o)
endmodule
